// ===== rtl/core/fdre_pkg.sv =====
// Shared types and constants of the frame delta run encoder.
package fdre_pkg;

   localparam int unsigned MAX_FRAME_PIXELS = 16777216;
   localparam int unsigned RUN_LIMIT        = 65535;

   localparam int unsigned THRESHOLD_W = 12;
   localparam int unsigned RUN_W       = 16;
   localparam int unsigned POS_W       = 25;
   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned CHANNEL_W   = 8;
   localparam int unsigned CHANNELS    = 4;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam int unsigned CLASS_DEPTH = 4;
   localparam int unsigned CLS_PTR_W   = $clog2(CLASS_DEPTH);
   localparam int unsigned CLS_CNT_W   = $clog2(CLASS_DEPTH + 1);

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [0:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_MERGE     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic similar;
      logic last;
   } class_type;

   typedef struct packed {
      logic [RUN_W-1:0] skip_count;
      logic [RUN_W-1:0] copy_count;
      logic [POS_W-1:0] end_position;
      logic             frame_done;
   } packet_type;

   typedef struct packed {
      logic       wr_a;
      logic       wr_b;
      packet_type a;
      packet_type b;
   } pkt_write_type;

endpackage

// ===== rtl/core/fdre_front.sv =====
// Front end: pixel pair compare and the class queue toward the run tracker.
module fdre_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [fdre_pkg::PIXEL_W-1:0]         req_previous_pixel,
   input  logic [fdre_pkg::PIXEL_W-1:0]         req_current_pixel,
   input  logic                                 req_last_pixel,
   input  logic [fdre_pkg::THRESHOLD_W-1:0]     threshold,
   output logic                                 cls_valid,
   output fdre_pkg::class_type                  cls_head,
   input  logic                                 cls_pop
);
   import fdre_pkg::*;

   class_type             cls_mem_ff [CLASS_DEPTH];
   logic [CLS_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CLS_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CLS_CNT_W-1:0]  count_ff, count_in;
   logic                  push;
   logic [CHANNEL_W-1:0]  diff [CHANNELS];
   logic [CHANNEL_W-1:0]  worst;
   class_type             cls_new;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         logic [CHANNEL_W-1:0] x;
         logic [CHANNEL_W-1:0] y;
         x = req_previous_pixel[i*CHANNEL_W +: CHANNEL_W];
         y = req_current_pixel[i*CHANNEL_W +: CHANNEL_W];
         diff[i] = (x > y) ? x - y : y - x;
      end
   end

   always_comb begin
      logic [CHANNEL_W-1:0] m01;
      logic [CHANNEL_W-1:0] m23;
      m01   = (diff[0] > diff[1]) ? diff[0] : diff[1];
      m23   = (diff[2] > diff[3]) ? diff[2] : diff[3];
      worst = (m01 > m23) ? m01 : m23;
   end

   always_comb begin
      cls_new.similar = (req_previous_pixel == req_current_pixel) ||
                        ({{(THRESHOLD_W-CHANNEL_W){1'b0}}, worst} < threshold);
      cls_new.last    = req_last_pixel;
   end

   assign req_full  = (count_ff == CLS_CNT_W'(CLASS_DEPTH));
   assign push      = req_push && !req_full;
   assign cls_valid = (count_ff != '0);
   assign cls_head  = cls_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + CLS_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cls_pop ? rd_ptr_ff + CLS_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cls_pop) begin
         count_in = count_ff + CLS_CNT_W'(1);
      end else if (!push && cls_pop) begin
         count_in = count_ff - CLS_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cls_mem_ff[wr_ptr_ff] <= cls_new;
      end
   end

endmodule

// ===== rtl/core/fdre_back.sv =====
// Back end: skip and copy run tracking and packet generation.
module fdre_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cls_valid,
   input  fdre_pkg::class_type              cls_head,
   output logic                             cls_pop,
   input  logic                             rsp_room,
   input  logic [fdre_pkg::RUN_W-1:0]       merge_window,
   output fdre_pkg::pkt_write_type          pkt_write
);
   import fdre_pkg::*;

   localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_FRAME_PIXELS - 1);
   localparam logic [RUN_W-1:0] RUN_LIMIT_V = RUN_W'(RUN_LIMIT);

   logic [RUN_W-1:0] skip_ff, skip_in;
   logic [RUN_W-1:0] copy_ff, copy_in;
   logic             pend_ff, pend_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic [POS_W-1:0] pos;
   logic             last;
   logic             limit;
   logic             close;
   logic [RUN_W-1:0] skip_a, copy_a, skip_b, copy_b;
   logic             pend_a, pend_b;
   logic [RUN_W:0]   merged;
   packet_type       first_pkt, last_pkt;

   assign cls_pop = cls_valid && rsp_room;

   always_comb begin
      pos    = (pos_ff >= POS_MAX) ? POS_MAX : pos_ff;
      last   = cls_head.last || (pos_ff >= POS_MAX);
      limit  = (copy_ff >= RUN_LIMIT_V) || (skip_ff >= RUN_LIMIT_V);
      skip_a = limit ? '0 : skip_ff;
      copy_a = limit ? '0 : copy_ff;
      pend_a = limit ? 1'b0 : pend_ff;
      merged = {1'b0, copy_a} + {1'b0, skip_a} + (RUN_W+1)'(1);
      close  = 1'b0;
      if (cls_head.similar) begin
         close  = pend_a;
         skip_b = (pend_a ? '0 : skip_a) + RUN_W'(1);
         copy_b = pend_a ? '0 : copy_a;
         pend_b = 1'b0;
      end else begin
         if (skip_a < merge_window) begin
            copy_b = merged[RUN_W-1:0];
            skip_b = '0;
         end else begin
            copy_b = copy_a + RUN_W'(1);
            skip_b = skip_a;
         end
         pend_b = 1'b1;
      end

      first_pkt.skip_count   = limit ? skip_ff : skip_a;
      first_pkt.copy_count   = limit ? copy_ff : copy_a;
      first_pkt.end_position = pos;
      first_pkt.frame_done   = 1'b0;

      last_pkt.skip_count    = skip_b;
      last_pkt.copy_count    = copy_b;
      last_pkt.end_position  = pos + POS_W'(1);
      last_pkt.frame_done    = 1'b1;
   end

   always_comb begin
      pkt_write.wr_a = 1'b0;
      pkt_write.wr_b = 1'b0;
      pkt_write.a    = first_pkt;
      pkt_write.b    = last_pkt;
      if (cls_pop) begin
         if (limit || close) begin
            pkt_write.wr_a = 1'b1;
            pkt_write.wr_b = last;
         end else begin
            pkt_write.wr_a = last;
            pkt_write.a    = last_pkt;
         end
      end
   end

   always_comb begin
      skip_in = skip_ff;
      copy_in = copy_ff;
      pend_in = pend_ff;
      pos_in  = pos_ff;
      if (cls_pop) begin
         if (last) begin
            skip_in = '0;
            copy_in = '0;
            pend_in = 1'b0;
            pos_in  = '0;
         end else begin
            skip_in = skip_b;
            copy_in = copy_b;
            pend_in = pend_b;
            pos_in  = pos + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
         copy_ff <= '0;
         pend_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         skip_ff <= skip_in;
         copy_ff <= copy_in;
         pend_ff <= pend_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

// ===== rtl/core/fdre_rsp_queue.sv =====
// Result queue: takes up to two packets per cycle, hands out one per transfer.
module fdre_rsp_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  fdre_pkg::pkt_write_type          pkt_write,
   output logic                             rsp_room,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output fdre_pkg::packet_type             rsp_head
);
   import fdre_pkg::*;

   packet_type            mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic [RSP_PTR_W-1:0]  wr_ptr_b;
   logic [RSP_CNT_W-1:0]  n_wr;
   logic                  pop;

   assign rsp_empty = (count_ff == '0);
   assign rsp_room  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign rsp_head  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_pop && !rsp_empty;
   assign wr_ptr_b  = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      n_wr      = RSP_CNT_W'(pkt_write.wr_a) + RSP_CNT_W'(pkt_write.wr_b);
      wr_ptr_in = wr_ptr_ff + n_wr[RSP_PTR_W-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + n_wr - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_write.wr_a) begin
         mem_ff[wr_ptr_ff] <= pkt_write.a;
      end
      if (pkt_write.wr_b) begin
         mem_ff[wr_ptr_b] <= pkt_write.b;
      end
   end

endmodule

// ===== rtl/core/frame_delta_run_encoder.sv =====
// Top level of the frame delta run encoder.
// Usage:
//   Input channel: drive req_push with a pixel pair (previous and current frame
//   word) and req_last_pixel on the final pixel of a frame; a transfer happens
//   on a clock edge with req_push high and req_full low.
//   Result channel: while rsp_empty is low the oldest packet header sits on
//   rsp_skip_count, rsp_copy_count, rsp_end_position and rsp_frame_done; it
//   is removed on an edge with rsp_pop high. rsp_frame_done closes a frame.
//   Configuration: csr_valid/csr_ready with csr_index and csr_wdata; ready is
//   always high. Write only while no pixel is in flight.
// Timing:
//   One pixel per cycle sustained while the receiver keeps up; the compare stage
//   feeds a four-entry class queue and the run tracker retires one pixel per
//   cycle from it while the result queue has room. A result passes through the
//   class queue and then the result queue before it reaches the result ports.
//   The run tracker takes a pixel only while the four-entry result queue has
//   at least two free slots.
//   When the receiver stalls, the result queue and then the class queue fill and req_full rises; nothing is dropped.
// Reset: synchronous; empties both queues, clears all runs, the pixel position
//   and both configuration registers.
module frame_delta_run_encoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [fdre_pkg::PIXEL_W-1:0]         req_previous_pixel,
   input  logic [fdre_pkg::PIXEL_W-1:0]         req_current_pixel,
   input  logic                                 req_last_pixel,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [fdre_pkg::RUN_W-1:0]           rsp_skip_count,
   output logic [fdre_pkg::RUN_W-1:0]           rsp_copy_count,
   output logic [fdre_pkg::POS_W-1:0]           rsp_end_position,
   output logic                                 rsp_frame_done,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  fdre_pkg::csr_index_type              csr_index,
   input  logic [fdre_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fdre_pkg::*;

   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;
   logic [RUN_W-1:0]       merge_ff, merge_in;
   logic                   cls_valid;
   class_type              cls_head;
   logic                   cls_pop;
   logic                   rsp_room;
   pkt_write_type          pkt_write;
   packet_type             rsp_head;

   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      merge_in     = merge_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_wdata[THRESHOLD_W-1:0];
            CSR_MERGE:     merge_in     = csr_wdata[RUN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         merge_ff     <= '0;
      end else begin
         threshold_ff <= threshold_in;
         merge_ff     <= merge_in;
      end
   end

   fdre_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_previous_pixel (req_previous_pixel),
      .req_current_pixel  (req_current_pixel),
      .req_last_pixel     (req_last_pixel),
      .threshold          (threshold_ff),
      .cls_valid          (cls_valid),
      .cls_head           (cls_head),
      .cls_pop            (cls_pop)
   );

   fdre_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cls_valid    (cls_valid),
      .cls_head     (cls_head),
      .cls_pop      (cls_pop),
      .rsp_room     (rsp_room),
      .merge_window (merge_ff),
      .pkt_write    (pkt_write)
   );

   fdre_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .pkt_write (pkt_write),
      .rsp_room  (rsp_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_skip_count   = rsp_head.skip_count;
   assign rsp_copy_count   = rsp_head.copy_count;
   assign rsp_end_position = rsp_head.end_position;
   assign rsp_frame_done   = rsp_head.frame_done;

endmodule

// ===== bench/tb_frame_delta_run_encoder.sv =====
// Self-checking testbench for the frame delta run encoder: directed rows and random frames.
module tb_frame_delta_run_encoder;
   import fdre_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 1000000;
   localparam int unsigned SETTLE_CYCLES  = 16;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int          FROM_PREDICTOR = -1;
   localparam int unsigned DIRECTED_ROWS  = 26;

   typedef enum logic [1:0] {
      ROW_PIXEL,
      ROW_THRESHOLD,
      ROW_MERGE
   } row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic [31:0]   prev;
      logic [31:0]   cur;
      logic          last;
      logic [15:0]   wdata;
      int            golden;
      packet_type    first;
      packet_type    second;
   } stimulus_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [PIXEL_W-1:0]    req_previous_pixel = '0;
   logic [PIXEL_W-1:0]    req_current_pixel = '0;
   logic                  req_last_pixel = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [RUN_W-1:0]      rsp_skip_count;
   logic [RUN_W-1:0]      rsp_copy_count;
   logic [POS_W-1:0]      rsp_end_position;
   logic                  rsp_frame_done;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state and configuration
   logic [THRESHOLD_W-1:0] cfg_threshold = '0;
   logic [RUN_W-1:0]       cfg_merge = '0;
   logic [RUN_W-1:0]       skip_len = '0;
   logic [RUN_W-1:0]       copy_len = '0;
   logic                   copy_open = 1'b0;
   logic [POS_W-1:0]       next_index = '0;

   packet_type  expected_packets [$];
   packet_type  seen;
   packet_type  want;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned packets_checked = 0;
   int unsigned frames_closed = 0;
   int unsigned full_stalls = 0;

   stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_PIXEL, 32'h00000000, 32'h00000000, 1'b1, 16'd0, 1,
        '{16'd1, 16'd0, 25'd1, 1'b1}, '0},
      '{ROW_PIXEL, 32'hffffffff, 32'h00000000, 1'b1, 16'd0, 1,
        '{16'd0, 16'd1, 25'd1, 1'b1}, '0},
      '{ROW_PIXEL, 32'hffffffff, 32'hffffffff, 1'b0, 16'd0, 0, '0, '0},
      '{ROW_PIXEL, 32'h00000000, 32'hffffffff, 1'b0, 16'd0, 0, '0, '0},
      '{ROW_PIXEL, 32'h12345678, 32'h12345678, 1'b0, 16'd0, 1,
        '{16'd1, 16'd1, 25'd2, 1'b0}, '0},
      '{ROW_PIXEL, 32'h80808080, 32'h7f808080, 1'b1, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_THRESHOLD, 32'h0, 32'h0, 1'b0, 16'd2550, 0, '0, '0},
      '{ROW_PIXEL, 32'h00000000, 32'hffffffff, 1'b1, 16'd0, 1,
        '{16'd1, 16'd0, 25'd1, 1'b1}, '0},
      '{ROW_THRESHOLD, 32'h0, 32'h0, 1'b0, 16'd16, 0, '0, '0},
      '{ROW_PIXEL, 32'h10203040, 32'h1f2f3f4f, 1'b0, 16'd0, 0, '0, '0},
      '{ROW_PIXEL, 32'h10203040, 32'h20203040, 1'b0, 16'd0, 0, '0, '0},
      '{ROW_PIXEL, 32'h00000000, 32'h00000000, 1'b1, 16'd0, 2,
        '{16'd1, 16'd1, 25'd2, 1'b0}, '{16'd1, 16'd0, 25'd3, 1'b1}},
      '{ROW_MERGE, 32'h0, 32'h0, 1'b0, 16'd3, 0, '0, '0},
      '{ROW_PIXEL, 32'ha5a5a5a5, 32'ha5a5a5a5, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'ha5a5a5a5, 32'ha5a5a5a5, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'h00000000, 32'hff00ff00, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'h5a5a5a5a, 32'h5a5a5a5a, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'h5a5a5a5a, 32'h5a5a5a5a, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'h5a5a5a5a, 32'h5a5a5a5a, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'h01020304, 32'hf1f2f3f4, 1'b1, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_MERGE, 32'h0, 32'h0, 1'b0, 16'hffff, 0, '0, '0},
      '{ROW_THRESHOLD, 32'h0, 32'h0, 1'b0, 16'd1, 0, '0, '0},
      '{ROW_PIXEL, 32'h000000ff, 32'h00000000, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'hff000000, 32'h00ffffff, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'h7f7f7f7f, 32'h7f7f7f7f, 1'b0, 16'd0, FROM_PREDICTOR, '0, '0},
      '{ROW_PIXEL, 32'h33333333, 32'h33333334, 1'b1, 16'd0, FROM_PREDICTOR, '0, '0}
   };

   frame_delta_run_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_previous_pixel (req_previous_pixel),
      .req_current_pixel  (req_current_pixel),
      .req_last_pixel     (req_last_pixel),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_skip_count     (rsp_skip_count),
      .rsp_copy_count     (rsp_copy_count),
      .rsp_end_position   (rsp_end_position),
      .rsp_frame_done     (rsp_frame_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d packets still due", cycle_count,
                  expected_packets.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic void advance_encoder(logic [31:0] prev, logic [31:0] cur,
                                           logic last_in, bit record);
      logic [POS_W-1:0] idx;
      logic [7:0]       a;
      logic [7:0]       b;
      logic [7:0]       gap;
      logic [7:0]       worst;
      logic             close;
      logic             similar;
      idx = next_index;
      close = last_in;
      worst = '0;
      if (idx >= MAX_FRAME_PIXELS - 1) begin
         idx = POS_W'(MAX_FRAME_PIXELS - 1);
         close = 1'b1;
      end
      if (copy_len >= RUN_LIMIT || skip_len >= RUN_LIMIT) begin
         if (record) expected_packets.push_back({skip_len, copy_len, idx, 1'b0});
         copy_open = 1'b0;
         skip_len = '0;
         copy_len = '0;
      end
      for (int lane = 0; lane < CHANNELS; lane++) begin
         a = prev[lane*8 +: 8];
         b = cur[lane*8 +: 8];
         gap = (a > b) ? a - b : b - a;
         if (gap > worst) worst = gap;
      end
      similar = (prev == cur) || ({4'b0, worst} < cfg_threshold);
      if (similar) begin
         if (copy_open) begin
            if (record) expected_packets.push_back({skip_len, copy_len, idx, 1'b0});
            copy_open = 1'b0;
            skip_len = '0;
            copy_len = '0;
         end
         skip_len++;
      end else begin
         copy_len++;
         if (skip_len < cfg_merge) begin
            copy_len += skip_len;
            skip_len = '0;
         end
         copy_open = 1'b1;
      end
      if (close) begin
         if (record) expected_packets.push_back({skip_len, copy_len, idx + 25'd1, 1'b1});
         skip_len = '0;
         copy_len = '0;
         copy_open = 1'b0;
         next_index = '0;
      end else begin
         next_index = idx + 25'd1;
      end
   endfunction

   // draw a pixel pair just inside or just outside the similarity threshold
   function automatic void make_pair(bit want_similar, output logic [31:0] prev,
                                     output logic [31:0] cur);
      int unsigned span;
      int unsigned gap_min;
      int unsigned hit_lane;
      int unsigned d;
      int unsigned lo;
      span = (cfg_threshold == 0) ? 0 : (cfg_threshold > 256) ? 255 : cfg_threshold - 1;
      gap_min = (cfg_threshold == 0) ? 1 : cfg_threshold;
      hit_lane = $urandom_range(3);
      prev = $urandom;
      cur = prev;
      if (want_similar && $urandom_range(2) == 0) return;
      for (int lane = 0; lane < CHANNELS; lane++) begin
         if (lane != hit_lane) d = $urandom_range(span);
         else if (want_similar) d = span;
         else if (gap_min > 255) d = $urandom_range(255);
         else if ($urandom_range(1) == 0) d = gap_min;
         else d = $urandom_range(255, gap_min);
         lo = $urandom_range(255 - d);
         if ($urandom_range(1) == 0) begin
            prev[lane*8 +: 8] = 8'(lo);
            cur[lane*8 +: 8]  = 8'(lo + d);
         end else begin
            prev[lane*8 +: 8] = 8'(lo + d);
            cur[lane*8 +: 8]  = 8'(lo);
         end
      end
   endfunction

   task automatic push_pixel(logic [31:0] prev, logic [31:0] cur, logic last_in, bit record);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push           <= 1'b1;
      req_previous_pixel <= prev;
      req_current_pixel  <= cur;
      req_last_pixel     <= last_in;
      @(posedge clock);
      while (req_full) begin
         full_stalls++;
         @(posedge clock);
      end
      pixels_sent++;
      advance_encoder(prev, cur, last_in, record);
   endtask

   task automatic drain_results();
      while (expected_packets.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [15:0] value);
      req_push <= 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_THRESHOLD) cfg_threshold = value[THRESHOLD_W-1:0];
      else cfg_merge = value;
   endtask

   // frames built from alternating similar and differing stretches, with some noise
   task automatic stream_frames(int unsigned items);
      int unsigned left_in_frame;
      int unsigned left_in_stretch;
      int unsigned stretch_max;
      bit          similar_stretch;
      logic        last_flag;
      logic [31:0] p;
      logic [31:0] c;
      left_in_frame = 0;
      left_in_stretch = 0;
      similar_stretch = 1'($urandom_range(1));
      for (int unsigned n = 0; n < items; n++) begin
         if (left_in_frame == 0) begin
            left_in_frame = ($urandom_range(99) < 85) ? $urandom_range(24, 1)
                                                      : $urandom_range(200, 25);
         end
         if (left_in_stretch == 0) begin
            similar_stretch = !similar_stretch;
            stretch_max = (cfg_merge < 10) ? cfg_merge + 2 : 12;
            left_in_stretch = ($urandom_range(3) == 0) ? $urandom_range(stretch_max, 1)
                                                       : $urandom_range(6, 1);
         end
         if ($urandom_range(9) == 0) begin
            p = $urandom;
            c = $urandom;
         end else begin
            make_pair(similar_stretch, p, c);
         end
         left_in_frame--;
         left_in_stretch--;
         last_flag = (left_in_frame == 0) || (n == items - 1);
         if (last_flag) left_in_frame = 0;
         push_pixel(p, c, last_flag, 1'b1);
      end
   endtask

   task automatic report_error(string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%s at cycle %0d: expected skip %0d copy %0d end %0d done %0d,",
                  what, cycle_count, want.skip_count, want.copy_count, want.end_position,
                  want.frame_done);
         $display("   got skip %0d copy %0d end %0d done %0d",
                  seen.skip_count, seen.copy_count, seen.end_position, seen.frame_done);
      end
   endtask

   // long receiver hold, counted down here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen = {rsp_skip_count, rsp_copy_count, rsp_end_position, rsp_frame_done};
            packets_checked++;
            if (seen.frame_done) frames_closed++;
            if (expected_packets.size() == 0) begin
               want = '0;
               report_error("unexpected packet");
            end else begin
               want = expected_packets.pop_front();
               if (seen.skip_count !== want.skip_count || seen.copy_count !== want.copy_count ||
                   seen.end_position !== want.end_position ||
                   seen.frame_done !== want.frame_done) begin
                  report_error("packet mismatch");
               end
            end
         end
         if (hold_left != 0) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_THRESHOLD: write_register(CSR_THRESHOLD, directed_rows[r].wdata);
            ROW_MERGE:     write_register(CSR_MERGE, directed_rows[r].wdata);
            default: begin
               push_pixel(directed_rows[r].prev, directed_rows[r].cur, directed_rows[r].last,
                          directed_rows[r].golden == FROM_PREDICTOR);
               if (directed_rows[r].golden > 0) expected_packets.push_back(directed_rows[r].first);
               if (directed_rows[r].golden > 1) expected_packets.push_back(directed_rows[r].second);
            end
         endcase
      end

      for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               write_register(CSR_THRESHOLD, 16'd0);
               write_register(CSR_MERGE, 16'd0);
            end
            1: begin
               write_register(CSR_THRESHOLD, 16'd16);
               write_register(CSR_MERGE, 16'd4);
            end
            2: begin
               write_register(CSR_THRESHOLD, 16'd255);
               write_register(CSR_MERGE, 16'd1);
            end
            3: begin
               write_register(CSR_THRESHOLD, 16'd256);
               write_register(CSR_MERGE, 16'hffff);
            end
            4: begin
               write_register(CSR_THRESHOLD, 16'd2550);
               write_register(CSR_MERGE, 16'd8);
            end
            5: begin
               write_register(CSR_THRESHOLD, 16'd1);
               write_register(CSR_MERGE, 16'd2);
            end
            6: begin
               write_register(CSR_THRESHOLD, 16'($urandom_range(300)));
               write_register(CSR_MERGE, 16'($urandom_range(12)));
            end
            default: begin
               write_register(CSR_THRESHOLD, 16'd100);
               write_register(CSR_MERGE, 16'hffff);
            end
         endcase
         case (ph % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 83;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 83;
            end
            default: begin
               sender_idle_pct = 27;
               receiver_stall_pct = 27;
            end
         endcase
         stream_frames(100);
         if (ph == 0 || ph == 4) hold_requests++;
         if (ph == 2 || ph == 7) begin
            req_push <= 1'b0;
            drain_results();
         end
         stream_frames(110);
      end

      req_push <= 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d pixels, %0d packet headers in %0d closed frames, %0d full cycles",
               pixels_sent, packets_checked, frames_closed, full_stalls);
      $display("thresholds 0 to 2550, merge windows 0 to 65535, long receiver holds; %0d errors",
               error_count);
      if (error_count == 0 && expected_packets.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== frame_delta_run_encoder.f =====
rtl/core/fdre_pkg.sv
rtl/core/fdre_front.sv
rtl/core/fdre_back.sv
rtl/core/fdre_rsp_queue.sv
rtl/core/frame_delta_run_encoder.sv
bench/tb_frame_delta_run_encoder.sv
